// ===== rtl/dvhs_pkg.sv =====
// Shared types and constants for the distinct value histogram.
`default_nettype none
package dvhs_pkg;
  localparam int MaxDistinct = 32;
  localparam int ValueBits = 32;
  localparam int CountBits = 16;
  localparam int IdxBits = $clog2(MaxDistinct);
  localparam int UsedBits = $clog2(MaxDistinct + 1);
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_SEL,
    ST_EMIT
  } dvhs_state_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic update;
    logic sel_start;
    logic sel_step;
    logic emit;
    logic clear;
  } dvhs_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic sel_done;
    logic last_item;
    logic out_last;
  } dvhs_sts_t;
endpackage
`default_nettype wire

// ===== rtl/dvhs_if.sv =====
// Valid/ready channel interfaces for input samples and histogram bins.
`default_nettype none
interface dvhs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_value;
  logic        set_end;
  modport source (output valid, sample_value, set_end, input ready);
  modport sink (input valid, sample_value, set_end, output ready);
endinterface

interface dvhs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] bin_value;
  logic [15:0] bin_count;
  logic        dropped_any;
  logic        run_end;
  modport source (output valid, bin_value, bin_count, dropped_any, run_end, input ready);
  modport sink (input valid, bin_value, bin_count, dropped_any, run_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/dvhs_ctrl.sv =====
// Controller state machine for the histogram.
`default_nettype none
module dvhs_ctrl
  import dvhs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire dvhs_sts_t sts,
  output dvhs_cmd_t      cmd
);
  dvhs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:   if (sts.scan_done) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = sts.last_item ? ST_SEL : ST_IDLE;
      ST_SEL:    if (sts.sel_done) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_ready) state_nxt = sts.out_last ? ST_IDLE : ST_SEL;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN:   cmd.scan_step = 1'b1;
      ST_UPDATE: begin
        cmd.update = 1'b1;
        cmd.sel_start = sts.last_item;
      end
      ST_SEL:    cmd.sel_step = 1'b1;
      ST_EMIT: begin
        out_valid = 1'b1;
        cmd.emit = out_ready;
        cmd.clear = out_ready && sts.out_last;
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input and output open together");
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_scan_next: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_SCAN) else $error("load did not scan");
`endif
endmodule
`default_nettype wire

// ===== rtl/dvhs_dp.sv =====
// Histogram table, linear match scan and selection sort datapath.
`default_nettype none
module dvhs_dp
  import dvhs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dvhs_cmd_t            cmd,
  input  wire logic [ValueBits-1:0] in_value,
  input  wire logic                 in_last,
  output dvhs_sts_t                 sts,
  output logic [ValueBits-1:0]      bin_value,
  output logic [CountBits-1:0]      bin_count,
  output logic                      dropped_any
);
  logic [ValueBits-1:0] vals_r [MaxDistinct];
  logic [CountBits-1:0] cnts_r [MaxDistinct];
  logic [MaxDistinct-1:0] taken_r;
  logic [UsedBits-1:0] used_r, emitted_r;
  logic                ovf_r, last_r, hit_r, best_ok_r;
  logic [ValueBits-1:0] val_r, best_val_r;
  logic [IdxBits-1:0]  hit_idx_r, best_idx_r;
  logic [UsedBits-1:0] ptr_r;
  logic [IdxBits-1:0]  pi;
  logic                better;

  assign pi = ptr_r[IdxBits-1:0];
  assign better = !best_ok_r ||
    ({~vals_r[pi][ValueBits-1], vals_r[pi][ValueBits-2:0]} <
     {~best_val_r[ValueBits-1], best_val_r[ValueBits-2:0]});

  assign sts.scan_done = hit_r || (ptr_r >= used_r);
  assign sts.sel_done  = ptr_r >= used_r;
  assign sts.last_item = last_r;
  assign sts.out_last  = (emitted_r + UsedBits'(1)) == used_r;
  assign bin_value   = best_val_r;
  assign bin_count   = cnts_r[best_idx_r];
  assign dropped_any = ovf_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r <= in_value;
      last_r <= in_last;
    end
    if (cmd.update && !hit_r && used_r != UsedBits'(MaxDistinct)) begin
      vals_r[used_r[IdxBits-1:0]] <= val_r;
      cnts_r[used_r[IdxBits-1:0]] <= CountBits'(1);
    end
    if (cmd.update && hit_r && cnts_r[hit_idx_r] != CountMax)
      cnts_r[hit_idx_r] <= cnts_r[hit_idx_r] + CountBits'(1);
    if (cmd.sel_step && ptr_r < used_r && !taken_r[pi] && better) begin
      best_val_r <= vals_r[pi];
      best_idx_r <= pi;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      ovf_r <= 1'b0;
      ptr_r <= '0;
      hit_r <= 1'b0;
      hit_idx_r <= '0;
      taken_r <= '0;
      emitted_r <= '0;
      best_ok_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        ptr_r <= '0;
        hit_r <= 1'b0;
      end
      if (cmd.scan_step && !sts.scan_done) begin
        if (vals_r[pi] == val_r) begin
          hit_r <= 1'b1;
          hit_idx_r <= pi;
        end else ptr_r <= ptr_r + UsedBits'(1);
      end
      if (cmd.update && !hit_r) begin
        if (used_r != UsedBits'(MaxDistinct)) used_r <= used_r + UsedBits'(1);
        else ovf_r <= 1'b1;
      end
      if (cmd.sel_start) begin
        ptr_r <= '0;
        best_ok_r <= 1'b0;
        taken_r <= '0;
        emitted_r <= '0;
      end
      if (cmd.sel_step && ptr_r < used_r) begin
        ptr_r <= ptr_r + UsedBits'(1);
        if (!taken_r[pi] && better) best_ok_r <= 1'b1;
      end
      if (cmd.emit) begin
        taken_r[best_idx_r] <= 1'b1;
        emitted_r <= emitted_r + UsedBits'(1);
        ptr_r <= '0;
        best_ok_r <= 1'b0;
      end
      if (cmd.clear) begin
        used_r <= '0;
        ovf_r <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UsedBits'(MaxDistinct)) else $error("table fill out of range");
  a_emit_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !taken_r[best_idx_r] && best_ok_r) else $error("entry emitted twice");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> used_r == '0 && !ovf_r) else $error("table not cleared");
`endif
endmodule
`default_nettype wire

// ===== rtl/distinct_value_histogram_sorted_top.sv =====
// Top level of the distinct value histogram with sorted output.
// Usage:
//   in  channel: one transaction per sample (sample_value, set_end).
//   out channel: after a transaction with set_end, one transaction per
//   distinct value in ascending signed order; run_end marks the last one,
//   dropped_any flags that a new value met a full 32-entry table.
// Timing:
//   A sample passes from its acceptance to the next accepting cycle through
//   the accept cycle, the match scan, which compares the table entries one
//   per cycle until a match or the end of the filled part (up to 32 entries)
//   and then settles, and the update cycle.
//   On set_end, each result then takes a selection pass over the n stored
//   entries and an emit cycle, which waits for out_ready.
//   After the last result the block returns to idle.
//   Only one transaction is in flight; in_ready is low while busy.
// Reset: synchronous active low rst_n empties the table and clears the
//   overflow flag; no clearing pass.
// Stall: a result waits on the out channel until taken; the table and the
//   input side hold meanwhile. After the last result the table is cleared.
`default_nettype none
module distinct_value_histogram_sorted_top
  import dvhs_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  dvhs_in_if.sink    in_ch,
  dvhs_out_if.source out_ch
);
  dvhs_cmd_t cmd;
  dvhs_sts_t sts;

  // Control: handshakes and sequencing.
  dvhs_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .sts, .cmd
  );

  // Datapath: table, match scan and sort.
  dvhs_dp u_dp (
    .clk, .rst_n, .cmd,
    .in_value   (in_ch.sample_value),
    .in_last    (in_ch.set_end),
    .sts,
    .bin_value  (out_ch.bin_value),
    .bin_count  (out_ch.bin_count),
    .dropped_any(out_ch.dropped_any)
  );

  // Last result of the run.
  assign out_ch.run_end = sts.out_last;
endmodule
`default_nettype wire
